>>> sv/hprl_pkg.sv
package hprl_pkg;

	// parameter defaults
	localparam int INTEG_W_DEF = 32;
	localparam int FRAC_DEF    = 8;

	// integrator is sign-extended to this width and fed to the multiplier in two halves
	localparam int ILO_W       = 24;
	localparam int INTEG_MAX_W = 2 * ILO_W;

	// shared multiplier: signed A by signed B
	localparam int MA_W  = 17;
	localparam int MB_W  = ILO_W + 1;
	localparam int MP_W  = MA_W + MB_W;
	localparam int ACC_W = MP_W + ILO_W;

	localparam int STEP_W = 4;

	// fixed-point constants
	localparam int STICK_SHIFT = 10;
	localparam int HALF_TURN   = 1800;
	localparam int TURN        = 3600;
	localparam int DRIVE_MAX   = 32767;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADBAND   = 3'd0,
		REG_DBAND_GAIN = 3'd1,
		REG_RATE_LIMIT = 3'd2,
		REG_KP_ANGLE   = 3'd3,
		REG_KI_ANGLE   = 3'd4,
		REG_KP_RATE    = 3'd5,
		REG_KD_RATE    = 3'd6,
		REG_STICK_SPAN = 3'd7
	} cfg_reg_t;

	localparam logic [10:0] DEADBAND_RST   = 11'd0;
	localparam logic [15:0] DBAND_GAIN_RST = 16'd256;
	localparam logic [15:0] RATE_LIMIT_RST = 16'd3000;
	localparam logic [10:0] STICK_SPAN_RST = 11'd300;

	// field widths
	localparam int HEAD_W = 12;
	localparam int STICK_W = 12;
	localparam int RATE_W = 17;
	localparam int DRIVE_W = 16;
	localparam int RT_W = 17;
	localparam int TGT_W = 14;
	localparam int ERR_W = 12;

	// input item layout
	localparam int I_NOW_LSB   = 0;
	localparam int I_CMD_LSB   = I_NOW_LSB + HEAD_W;
	localparam int I_STICK_LSB = I_CMD_LSB + HEAD_W;
	localparam int I_EN_BIT    = I_STICK_LSB + STICK_W;
	localparam int I_RATE_LSB  = I_EN_BIT + 1;
	localparam int I_CLR_BIT   = I_RATE_LSB + RATE_W;
	localparam int IN_BITS     = I_CLR_BIT + 1;
	localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;

	// result item layout
	localparam int O_DRIVE_LSB = 0;
	localparam int O_RT_LSB    = O_DRIVE_LSB + DRIVE_W;
	localparam int O_TGT_LSB   = O_RT_LSB + RT_W;
	localparam int O_ERR_LSB   = O_TGT_LSB + TGT_W;
	localparam int OUT_BITS    = O_ERR_LSB + ERR_W;
	localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

	// microcode word
	typedef enum logic [2:0] {
		MA_STICK, MA_GAIN, MA_KPA, MA_KIA, MA_KPR, MA_KDR
	} ma_sel_t;

	typedef enum logic [2:0] {
		MB_SPAN, MB_ERR, MB_ILO, MB_IHI, MB_RERR, MB_DERR
	} mb_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_ADD_HI, ACC_SUB
	} acc_op_t;

	typedef enum logic [2:0] {
		WB_NONE, WB_TARGET, WB_WRAP, WB_SCALE, WB_INTEG, WB_RT, WB_RERR, WB_DRIVE
	} wb_op_t;

	typedef enum logic {
		JC_NONE, JC_OUT_DB
	} jcond_t;

	typedef struct packed {
		ma_sel_t           ma;
		mb_sel_t           mb;
		acc_op_t           acc;
		wb_op_t            wb;
		jcond_t            jc;
		logic [STEP_W-1:0] jto;
	} ctrl_t;

	typedef struct packed {
		logic out_db;
		logic stall;
	} seq_stat_t;

	localparam ctrl_t CW_IDLE = '{
		ma: MA_STICK, mb: MB_SPAN, acc: ACC_HOLD, wb: WB_NONE, jc: JC_NONE, jto: '0
	};

endpackage

>>> sv/heading_pi_rate_pd_loop.sv
// Heading hold controller: a PI stage on the wrapped heading error (with deadband scaling and a
// conditional anti-windup integrator) produces a clamped yaw rate target, and a PD stage on the
// rate error produces a saturated Q15 tail drive. Items are processed one at a time by a
// twelve-step microcode program driving a single shared 17x25 signed multiplier, one product per
// step; the scaling step is skipped when the error lies outside the deadband, and a new item is
// taken only once the program for the previous one has finished. The result register lets the
// next item be accepted while the previous result still waits; the final step waits only if that
// register is still occupied. Configuration writes are taken at any edge with cfg_we high and
// must arrive while idle.
module heading_pi_rate_pd_loop #(
	parameter int INTEGRATOR_WIDTH = hprl_pkg::INTEG_W_DEF,
	parameter int GAIN_FRAC_BITS   = hprl_pkg::FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// heading_now, heading_cmd, stick_yaw, stick_enable, rate_now, clear_integrator
	input  logic [hprl_pkg::IN_W-1:0]       s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// drive, rate_target, heading_target, heading_error
	output logic [hprl_pkg::OUT_W-1:0]      m_tdata,
	input  logic                            cfg_we,
	input  logic [hprl_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [hprl_pkg::CFG_W-1:0]      cfg_data
);
	import hprl_pkg::*;

	localparam int IW = INTEGRATOR_WIDTH;

	// configuration
	logic        [10:0] deadband_q;
	logic        [15:0] dgain_q;
	logic        [15:0] rlim_q;
	logic signed [15:0] kpa_q;
	logic signed [15:0] kia_q;
	logic signed [15:0] kpr_q;
	logic signed [15:0] kdr_q;
	logic        [10:0] span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RST;
			dgain_q    <= DBAND_GAIN_RST;
			rlim_q     <= RATE_LIMIT_RST;
			kpa_q      <= '0;
			kia_q      <= '0;
			kpr_q      <= '0;
			kdr_q      <= '0;
			span_q     <= STICK_SPAN_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_DEADBAND:   deadband_q <= cfg_data[10:0];
				REG_DBAND_GAIN: dgain_q    <= cfg_data;
				REG_RATE_LIMIT: rlim_q     <= cfg_data;
				REG_KP_ANGLE:   kpa_q      <= $signed(cfg_data);
				REG_KI_ANGLE:   kia_q      <= $signed(cfg_data);
				REG_KP_RATE:    kpr_q      <= $signed(cfg_data);
				REG_KD_RATE:    kdr_q      <= $signed(cfg_data);
				REG_STICK_SPAN: span_q     <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// input capture
	logic                accept;
	logic                busy;
	logic [HEAD_W-1:0]   now_q;
	logic [HEAD_W-1:0]   cmd_q;
	logic signed [STICK_W-1:0] stick_q;
	logic                en_q;
	logic signed [RATE_W-1:0]  rate_q;
	logic                clr_q;

	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q   <= s_tdata[I_NOW_LSB +: HEAD_W];
			cmd_q   <= s_tdata[I_CMD_LSB +: HEAD_W];
			stick_q <= $signed(s_tdata[I_STICK_LSB +: STICK_W]);
			en_q    <= s_tdata[I_EN_BIT];
			rate_q  <= $signed(s_tdata[I_RATE_LSB +: RATE_W]);
			clr_q   <= s_tdata[I_CLR_BIT];
		end
	end

	// sequencer
	ctrl_t     ctrl;
	seq_stat_t stat;
	logic      m_tvalid_q;

	hprl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// datapath registers
	logic signed [TGT_W-1:0]       target_q;
	logic signed [ERR_W-1:0]       err_q;
	logic signed [IW-1:0]          integ_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [RT_W-1:0]        rt_q;
	logic signed [RT_W:0]          rerr_q;
	logic signed [RT_W+1:0]        derr_q;
	logic signed [RT_W-1:0]        last_rt_q;
	logic signed [RT_W:0]          last_rerr_q;

	// shared multiplier
	logic signed [INTEG_MAX_W-1:0] integ_x;
	logic signed [MA_W-1:0]        ma;
	logic signed [MB_W-1:0]        mb;
	logic signed [MP_W-1:0]        prod;
	logic signed [ACC_W-1:0]       pext;

	assign integ_x = INTEG_MAX_W'(integ_q);

	always_comb begin
		case (ctrl.ma)
			MA_STICK: ma = MA_W'(stick_q);
			MA_GAIN:  ma = $signed({1'b0, dgain_q});
			MA_KPA:   ma = MA_W'(kpa_q);
			MA_KIA:   ma = MA_W'(kia_q);
			MA_KPR:   ma = MA_W'(kpr_q);
			MA_KDR:   ma = MA_W'(kdr_q);
			default:  ma = '0;
		endcase
		case (ctrl.mb)
			MB_SPAN: mb = $signed(MB_W'(span_q));
			MB_ERR:  mb = MB_W'(err_q);
			MB_ILO:  mb = $signed({1'b0, integ_x[ILO_W-1:0]});
			MB_IHI:  mb = MB_W'($signed(integ_x[INTEG_MAX_W-1:ILO_W]));
			MB_RERR: mb = MB_W'(rerr_q);
			MB_DERR: mb = MB_W'(derr_q);
			default: mb = '0;
		endcase
	end

	assign prod = ma * mb;
	assign pext = ACC_W'(prod);

	always_ff @(posedge clk) begin
		case (ctrl.acc)
			ACC_LOAD:   acc_q <= pext;
			ACC_ADD:    acc_q <= acc_q + pext;
			ACC_ADD_HI: acc_q <= acc_q + (pext <<< ILO_W);
			ACC_SUB:    acc_q <= acc_q - pext;
			default: ;
		endcase
	end

	// heading target and wrapped error
	logic signed [TGT_W-1:0] tgt_next;
	logic signed [TGT_W:0]   diff;
	logic signed [TGT_W:0]   wrapped;

	assign tgt_next = TGT_W'($signed({2'b00, cmd_q}))
		+ (en_q ? TGT_W'(prod >>> STICK_SHIFT) : TGT_W'(0));
	assign diff = (TGT_W+1)'(target_q) - (TGT_W+1)'($signed({1'b0, now_q}));

	always_comb begin
		if (diff > (TGT_W+1)'(HALF_TURN + TURN)) begin
			wrapped = diff - (TGT_W+1)'(2 * TURN);
		end else if (diff > (TGT_W+1)'(HALF_TURN)) begin
			wrapped = diff - (TGT_W+1)'(TURN);
		end else if (diff < -(TGT_W+1)'(HALF_TURN + TURN)) begin
			wrapped = diff + (TGT_W+1)'(2 * TURN);
		end else if (diff < -(TGT_W+1)'(HALF_TURN)) begin
			wrapped = diff + (TGT_W+1)'(TURN);
		end else begin
			wrapped = diff;
		end
	end

	// deadband test and scaling
	logic        [ERR_W-1:0] err_mag;
	logic signed [MP_W-1:0]  scaled;
	logic signed [ERR_W-1:0] scaled_sat;

	assign err_mag     = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
	assign stat.out_db = (err_mag >= {1'b0, deadband_q});
	assign stat.stall  = m_tvalid_q && !m_tready;
	assign scaled      = prod >>> GAIN_FRAC_BITS;

	always_comb begin
		if (scaled > MP_W'(HALF_TURN)) begin
			scaled_sat = ERR_W'(HALF_TURN);
		end else if (scaled < -MP_W'(HALF_TURN)) begin
			scaled_sat = -ERR_W'(HALF_TURN);
		end else begin
			scaled_sat = ERR_W'(scaled);
		end
	end

	// integrator with windup guard on the previous rate target
	logic signed [RT_W:0]  lim;
	logic signed [RT_W:0]  last_rt_x;
	logic                  do_acc;
	logic signed [IW-1:0]  ibase;
	logic signed [IW:0]    isum;
	logic signed [IW-1:0]  isat;

	assign lim       = $signed({2'b00, rlim_q});
	assign last_rt_x = (RT_W+1)'(last_rt_q);
	assign ibase     = clr_q ? IW'(0) : integ_q;
	assign isum      = (IW+1)'(ibase) + (IW+1)'(err_q);

	always_comb begin
		if (last_rt_x >= lim) begin
			do_acc = err_q < 0;
		end else if (last_rt_x <= -lim) begin
			do_acc = err_q > 0;
		end else begin
			do_acc = 1'b1;
		end
		if (isum[IW] != isum[IW-1]) begin
			isat = isum[IW] ? $signed({1'b1, {(IW-1){1'b0}}}) : $signed({1'b0, {(IW-1){1'b1}}});
		end else begin
			isat = isum[IW-1:0];
		end
	end

	// rate target clamp and drive saturation
	logic signed [ACC_W-1:0] acc_sh;
	logic signed [ACC_W-1:0] lim_x;
	logic signed [RT_W-1:0]  rt_next;
	logic signed [DRIVE_W-1:0] drive_next;

	assign acc_sh = acc_q >>> GAIN_FRAC_BITS;
	assign lim_x  = ACC_W'(lim);

	always_comb begin
		if (acc_sh > lim_x) begin
			rt_next = RT_W'(lim);
		end else if (acc_sh < -lim_x) begin
			rt_next = RT_W'(-lim);
		end else begin
			rt_next = RT_W'(acc_sh);
		end
		if (acc_sh > ACC_W'(DRIVE_MAX)) begin
			drive_next = DRIVE_W'(DRIVE_MAX);
		end else if (acc_sh < -ACC_W'(DRIVE_MAX)) begin
			drive_next = -DRIVE_W'(DRIVE_MAX);
		end else begin
			drive_next = DRIVE_W'(acc_sh);
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (ctrl.wb)
			WB_TARGET: target_q <= tgt_next;
			WB_WRAP:   err_q    <= ERR_W'(wrapped);
			WB_SCALE:  err_q    <= scaled_sat;
			WB_RT:     rt_q     <= rt_next;
			WB_RERR: begin
				rerr_q <= (RT_W+1)'(rt_q) - (RT_W+1)'(rate_q);
				derr_q <= (RT_W+2)'(rt_q) - (RT_W+2)'(rate_q) - (RT_W+2)'(last_rerr_q);
			end
			default: ;
		endcase
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			last_rt_q   <= '0;
			last_rerr_q <= '0;
		end else begin
			case (ctrl.wb)
				WB_INTEG: integ_q <= do_acc ? isat : ibase;
				WB_DRIVE: begin
					last_rt_q   <= rt_q;
					last_rerr_q <= rerr_q;
				end
				default: ;
			endcase
		end
	end

	// result register
	logic signed [DRIVE_W-1:0] out_drive_q;
	logic signed [RT_W-1:0]    out_rt_q;
	logic signed [TGT_W-1:0]   out_tgt_q;
	logic signed [ERR_W-1:0]   out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.wb == WB_DRIVE) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wb == WB_DRIVE) begin
			out_drive_q <= drive_next;
			out_rt_q    <= rt_q;
			out_tgt_q   <= target_q;
			out_err_q   <= err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, out_err_q, out_tgt_q, out_rt_q, out_drive_q};

endmodule

>>> sv/hprl_seq.sv
module hprl_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  hprl_pkg::seq_stat_t stat,
	output hprl_pkg::ctrl_t     ctrl,
	output logic                busy
);
	import hprl_pkg::*;

	localparam logic [STEP_W-1:0] ST_TARGET = STEP_W'(0);
	localparam logic [STEP_W-1:0] ST_WRAP   = STEP_W'(1);
	localparam logic [STEP_W-1:0] ST_DBTEST = STEP_W'(2);
	localparam logic [STEP_W-1:0] ST_SCALE  = STEP_W'(3);
	localparam logic [STEP_W-1:0] ST_INTEG  = STEP_W'(4);
	localparam logic [STEP_W-1:0] ST_ILO    = STEP_W'(5);
	localparam logic [STEP_W-1:0] ST_IHI    = STEP_W'(6);
	localparam logic [STEP_W-1:0] ST_RT     = STEP_W'(7);
	localparam logic [STEP_W-1:0] ST_RERR   = STEP_W'(8);
	localparam logic [STEP_W-1:0] ST_PR     = STEP_W'(9);
	localparam logic [STEP_W-1:0] ST_DR     = STEP_W'(10);
	localparam logic [STEP_W-1:0] ST_DRIVE  = STEP_W'(11);

	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = CW_IDLE;
		case (step)
			ST_TARGET: begin
				w.ma = MA_STICK;
				w.mb = MB_SPAN;
				w.wb = WB_TARGET;
			end
			ST_WRAP: begin
				w.wb = WB_WRAP;
			end
			ST_DBTEST: begin
				w.jc  = JC_OUT_DB;
				w.jto = ST_INTEG;
			end
			ST_SCALE: begin
				w.ma = MA_GAIN;
				w.mb = MB_ERR;
				w.wb = WB_SCALE;
			end
			ST_INTEG: begin
				// proportional product runs beside the integrator update
				w.ma  = MA_KPA;
				w.mb  = MB_ERR;
				w.acc = ACC_LOAD;
				w.wb  = WB_INTEG;
			end
			ST_ILO: begin
				w.ma  = MA_KIA;
				w.mb  = MB_ILO;
				w.acc = ACC_ADD;
			end
			ST_IHI: begin
				w.ma  = MA_KIA;
				w.mb  = MB_IHI;
				w.acc = ACC_ADD_HI;
			end
			ST_RT: begin
				w.wb = WB_RT;
			end
			ST_RERR: begin
				w.wb = WB_RERR;
			end
			ST_PR: begin
				w.ma  = MA_KPR;
				w.mb  = MB_RERR;
				w.acc = ACC_LOAD;
			end
			ST_DR: begin
				w.ma  = MA_KDR;
				w.mb  = MB_DERR;
				w.acc = ACC_SUB;
			end
			ST_DRIVE: begin
				w.wb = WB_DRIVE;
			end
			default: begin
				w = CW_IDLE;
			end
		endcase
		return w;
	endfunction

	logic              run_q;
	logic [STEP_W-1:0] step_q;
	ctrl_t             word;
	logic              last;
	logic              hold;

	assign word = ucode(step_q);
	assign last = (word.wb == WB_DRIVE);
	// last step waits while the result register is still full and not being taken
	assign hold = last && stat.stall;
	assign ctrl = (run_q && !hold) ? word : CW_IDLE;
	assign busy = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= ST_TARGET;
		end else if (start) begin
			run_q  <= 1'b1;
			step_q <= ST_TARGET;
		end else if (run_q && !hold) begin
			if (last) begin
				run_q <= 1'b0;
			end else if (word.jc == JC_OUT_DB && stat.out_db) begin
				step_q <= word.jto;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

>>> sv/hprl_chk.sv
module hprl_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [hprl_pkg::OUT_W-1:0]     m_tdata
);
	import hprl_pkg::*;

	logic signed [ERR_W-1:0]   err_f;
	logic        [DRIVE_W-1:0] drive_f;
	logic        [RT_W-1:0]    rt_f;

	assign err_f   = $signed(m_tdata[O_ERR_LSB +: ERR_W]);
	assign drive_f = m_tdata[O_DRIVE_LSB +: DRIVE_W];
	assign rt_f    = m_tdata[O_RT_LSB +: RT_W];

	// one item in flight: no new item right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while previous one still in work");

	// a new result only appears at the end of an item's work
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without an item in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result item changed");

	// saturation keeps drive and rate target symmetric
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> drive_f != {1'b1, {(DRIVE_W-1){1'b0}}} && rt_f != {1'b1, {(RT_W-1){1'b0}}})
		else $error("drive or rate target left its saturated range");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> err_f <= ERR_W'(HALF_TURN) && err_f >= -ERR_W'(HALF_TURN))
		else $error("heading error outside half turn");

endmodule

bind heading_pi_rate_pd_loop hprl_chk u_hprl_chk (.*);
